// File: hw/rtl/vda_pkg.sv
// ----------------------------------------------------------------------------
// vda_pkg
// Shared widths, mode codes and helpers for the vector distance accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package vda_pkg;

   localparam int VAL_W      = 32;   // Q16.16 element
   localparam int SUM_W      = 33;   // x + y
   localparam int ACC_W      = 48;   // Q32.16 accumulator
   localparam int FRAC_W     = 16;
   localparam int MODE_W     = 2;
   localparam int TERM_STEPS = FRAC_W + 1;  // quotient bits of one canberra term

   localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

   localparam logic [MODE_W-1:0] MODE_MANHATTAN = 2'd0;
   localparam logic [MODE_W-1:0] MODE_MAXIMUM   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CANBERRA  = 2'd2;

   // divider command: start pulse, scale selects the long final division
   typedef struct packed {
      logic start;
      logic scale;
   } div_ctrl_type;

   function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                input logic [ACC_W-1:0] b);
      logic [ACC_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[ACC_W] ? ACC_MAX : s[ACC_W-1:0];
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/vda_divider.sv
// ----------------------------------------------------------------------------
// vda_divider
// Restoring divider, one quotient bit per cycle, shared by the per-pair
// canberra term and the final length scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module vda_divider #(
   parameter int DW = 61
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire vda_pkg::div_ctrl_type     ctrl,
   input  wire logic [vda_pkg::SUM_W-1:0] divisor,
   input  wire logic [vda_pkg::SUM_W-1:0] rem_init,
   input  wire logic [DW-1:0]             dividend,
   output logic                           done,
   output logic [vda_pkg::ACC_W-1:0]      quotient,
   output logic                           overflow
);
   import vda_pkg::*;

   localparam int CNT_W = $clog2(DW + 1);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [SUM_W-1:0]   dvs_ff, dvs_in;
   logic [SUM_W-1:0]   rem_ff, rem_in;
   logic [DW-1:0]      dvd_ff, dvd_in;
   logic [ACC_W-1:0]   quo_ff, quo_in;
   logic               ovf_ff, ovf_in;

   logic [SUM_W:0]     rem_sh;
   logic [SUM_W:0]     rem_sub;
   logic               ge;

   always_comb begin
      rem_sh  = {rem_ff, dvd_ff[DW-1]};
      rem_sub = rem_sh - {1'b0, dvs_ff};
      ge      = rem_sh >= {1'b0, dvs_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      ovf_in  = ovf_ff;

      if (ctrl.start) begin
         busy_in = 1'b1;
         cnt_in  = ctrl.scale ? CNT_W'(DW) : CNT_W'(TERM_STEPS);
         dvs_in  = divisor;
         rem_in  = rem_init;
         dvd_in  = dividend;
         quo_in  = '0;
         ovf_in  = 1'b0;
      end else if (busy_ff) begin
         rem_in = ge ? rem_sub[SUM_W-1:0] : rem_sh[SUM_W-1:0];
         dvd_in = {dvd_ff[DW-2:0], 1'b0};
         quo_in = {quo_ff[ACC_W-2:0], ge};
         ovf_in = ovf_ff | quo_ff[ACC_W-1];   // quotient bit beyond 48 bits
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      ovf_ff <= ovf_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
   assign overflow = ovf_ff;

endmodule

`default_nettype wire

// File: hw/rtl/vda_multiplier.sv
// ----------------------------------------------------------------------------
// vda_multiplier
// Shift-add multiplier, one multiplier bit per cycle, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module vda_multiplier #(
   parameter int AW = 48,
   parameter int BW = 13
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [AW-1:0]      a_value,
   input  wire logic [BW-1:0]      b_value,
   output logic                    done,
   output logic [AW+BW-1:0]        product
);

   localparam int PW    = AW + BW;
   localparam int CNT_W = $clog2(BW + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [AW-1:0]    a_ff, a_in;
   logic [BW-1:0]    b_ff, b_in;
   logic [PW-1:0]    p_ff, p_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      p_in    = p_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(BW);
         a_in    = a_value;
         b_in    = b_value;
         p_in    = '0;
      end else if (busy_ff) begin
         p_in   = {p_ff[PW-2:0], 1'b0} + (b_ff[BW-1] ? PW'(a_ff) : PW'(0));
         b_in   = b_ff << 1;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      p_ff   <= p_in;
   end

   assign done    = done_ff;
   assign product = p_ff;

endmodule

`default_nettype wire

// File: hw/rtl/vector_distance_accumulator.sv
// ----------------------------------------------------------------------------
// vector_distance_accumulator
// Streams element pairs of two vectors and emits one Manhattan, maximum or
// Canberra distance per vector.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel (valid/ready): one x/y Q16.16 pair per item, req_last marks
//    the final pair. req_ready is high only while the sequencer is idle.
//  - rsp channel (valid/ready): one item per vector, distance in Q32.16
//    (saturating) plus all_zero_flag for a Canberra vector with no nonzero
//    x+y. Result sits in an output register; a stalled receiver does not
//    block accepting the next vector's pairs, only the next result hand-off.
//  - csr_write_enable/csr_write_data set distance_mode; write it while idle.
// Processing per item:
//  - Manhattan/maximum pair: folded in when accepted; a last pair then passes
//    the decide and hand-off states.
//  - Canberra pair with x+y != 0: waits for the 17 quotient bits of the
//    shared restoring divider. A Canberra last pair additionally scales the
//    sum by count/nonzero via a CW-bit shift-add multiply, then a 48+CW-bit
//    division in the divider, CW = clog2(MAX_LENGTH+1) (13 for 4096).
// Reset: synchronous, clears mode (Manhattan), sums, counts and rsp_valid.
// ----------------------------------------------------------------------------
`default_nettype none

module vector_distance_accumulator #(
   parameter int MAX_LENGTH = 4096
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [vda_pkg::VAL_W-1:0]  req_x_value,
   input  wire logic [vda_pkg::VAL_W-1:0]  req_y_value,
   input  wire logic                       req_last,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [vda_pkg::ACC_W-1:0]       rsp_distance,
   output logic                            rsp_all_zero_flag,
   input  wire logic                       csr_write_enable,
   input  wire logic [vda_pkg::MODE_W-1:0] csr_write_data
);
   import vda_pkg::*;

   localparam int CW = $clog2(MAX_LENGTH + 1);   // count width
   localparam int DW = ACC_W + CW;               // scaled product width
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_LENGTH);

   // sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;  // take pairs
   localparam logic [2:0] ST_TERM   = 3'd1;  // canberra term division
   localparam logic [2:0] ST_POST   = 3'd2;  // pick final form
   localparam logic [2:0] ST_MUL    = 3'd3;  // sum * element count
   localparam logic [2:0] ST_SCALE  = 3'd4;  // / nonzero count
   localparam logic [2:0] ST_FINISH = 3'd5;  // hand result to output reg

   logic [2:0]        state_ff, state_in;
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [MODE_W-1:0] item_mode_ff, item_mode_in;
   logic              last_ff, last_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [CW-1:0]     ec_ff, ec_in;
   logic [CW-1:0]     nz_ff, nz_in;
   logic [ACC_W-1:0]  res_dist_ff, res_dist_in;
   logic              res_flag_ff, res_flag_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ACC_W-1:0]  rsp_dist_ff, rsp_dist_in;
   logic              rsp_flag_ff, rsp_flag_in;

   // pair arithmetic
   logic [VAL_W-1:0]  diff;
   logic [SUM_W-1:0]  sum;
   logic              sum_nz;
   logic              accept;

   // shared units
   div_ctrl_type      div_ctrl;
   logic [SUM_W-1:0]  div_divisor;
   logic [SUM_W-1:0]  div_rem_init;
   logic [DW-1:0]     div_dividend;
   logic              div_done;
   logic [ACC_W-1:0]  div_quotient;
   logic              div_overflow;
   logic              mul_start;
   logic              mul_done;
   logic [DW-1:0]     mul_product;

   assign accept = req_valid && req_ready;
   assign diff   = (req_x_value >= req_y_value) ? req_x_value - req_y_value
                                                : req_y_value - req_x_value;
   assign sum    = {1'b0, req_x_value} + {1'b0, req_y_value};
   assign sum_nz = sum != '0;

   // term: (diff << 16) / sum; quotient < 2^17, so the top 31 dividend bits
   // seed the remainder and diff[0] then 16 zeros are shifted in.
   // scale: product / nonzero count, all product bits shifted in.
   always_comb begin
      if (div_ctrl.scale) begin
         div_divisor  = SUM_W'(nz_ff);
         div_rem_init = '0;
         div_dividend = mul_product;
      end else begin
         div_divisor  = sum;
         div_rem_init = SUM_W'(diff >> 1);
         div_dividend = {diff[0], {(DW-1){1'b0}}};
      end
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = csr_write_enable ? csr_write_data : mode_ff;
      item_mode_in = item_mode_ff;
      last_in      = last_ff;
      acc_in       = acc_ff;
      ec_in        = ec_ff;
      nz_in        = nz_ff;
      res_dist_in  = res_dist_ff;
      res_flag_in  = res_flag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_dist_in  = rsp_dist_ff;
      rsp_flag_in  = rsp_flag_ff;
      div_ctrl     = '0;
      mul_start    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               item_mode_in = mode_ff;
               last_in      = req_last;
               ec_in        = (ec_ff >= CNT_MAX) ? CNT_MAX : ec_ff + CW'(1);
               if (sum_nz) begin
                  nz_in = (nz_ff >= CNT_MAX) ? CNT_MAX : nz_ff + CW'(1);
               end
               state_in = req_last ? ST_POST : ST_IDLE;
               case (mode_ff)
                  MODE_MAXIMUM: begin
                     if (ACC_W'(diff) > acc_ff) begin
                        acc_in = ACC_W'(diff);
                     end
                  end
                  MODE_CANBERRA: begin
                     if (sum_nz) begin
                        div_ctrl.start = 1'b1;
                        state_in       = ST_TERM;
                     end
                  end
                  default: begin
                     acc_in = sat_add(acc_ff, ACC_W'(diff));
                  end
               endcase
            end
         end
         ST_TERM: begin
            if (div_done) begin
               acc_in   = sat_add(acc_ff, div_quotient);
               state_in = last_ff ? ST_POST : ST_IDLE;
            end
         end
         ST_POST: begin
            if (item_mode_ff == MODE_CANBERRA) begin
               if (nz_ff == '0) begin
                  res_dist_in = '0;
                  res_flag_in = 1'b1;
                  state_in    = ST_FINISH;
               end else begin
                  mul_start = 1'b1;
                  state_in  = ST_MUL;
               end
            end else begin
               res_dist_in = acc_ff;
               res_flag_in = 1'b0;
               state_in    = ST_FINISH;
            end
         end
         ST_MUL: begin
            if (mul_done) begin
               div_ctrl.start = 1'b1;
               div_ctrl.scale = 1'b1;
               state_in       = ST_SCALE;
            end
         end
         ST_SCALE: begin
            if (div_done) begin
               res_dist_in = div_overflow ? ACC_MAX : div_quotient;
               res_flag_in = 1'b0;
               state_in    = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // wait for the output register to free up, then start a new vector
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_dist_in  = res_dist_ff;
               rsp_flag_in  = res_flag_ff;
               acc_in       = '0;
               ec_in        = '0;
               nz_in        = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_MANHATTAN;
         acc_ff       <= '0;
         ec_ff        <= '0;
         nz_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         acc_ff       <= acc_in;
         ec_ff        <= ec_in;
         nz_ff        <= nz_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_mode_ff <= item_mode_in;
      last_ff      <= last_in;
      res_dist_ff  <= res_dist_in;
      res_flag_ff  <= res_flag_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_flag_ff  <= rsp_flag_in;
   end

   vda_divider #(
      .DW (DW)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .divisor  (div_divisor),
      .rem_init (div_rem_init),
      .dividend (div_dividend),
      .done     (div_done),
      .quotient (div_quotient),
      .overflow (div_overflow)
   );

   vda_multiplier #(
      .AW (ACC_W),
      .BW (CW)
   ) u_multiplier (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a_value (acc_ff),
      .b_value (ec_ff),
      .done    (mul_done),
      .product (mul_product)
   );

   assign req_ready         = state_ff == ST_IDLE;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_distance      = rsp_dist_ff;
   assign rsp_all_zero_flag = rsp_flag_ff;

   // nonzero pairs never outnumber pairs
   a_count_order: assert property (@(posedge clock) disable iff (reset)
      nz_ff <= ec_ff)
      else $error("nonzero count exceeds element count");

   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      ec_ff <= CNT_MAX)
      else $error("element count above MAX_LENGTH");

   // a canberra term never exceeds 1.0
   a_term_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TERM && div_done) |->
         (div_quotient <= (ACC_W'(1) << FRAC_W) && !div_overflow))
      else $error("canberra term out of range");

   // flagged result always carries zero distance
   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_flag_ff) |-> (rsp_dist_ff == '0))
      else $error("all-zero flag with nonzero distance");

   // a non-last manhattan/maximum pair leaves the sequencer idle in the next cycle
   a_fast_pair: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_last && mode_ff != MODE_CANBERRA) |=>
         (state_ff == ST_IDLE))
      else $error("plain pair did not return to idle");

endmodule

`default_nettype wire
